@@ hdl/inp_pkg.sv @@
// inp_pkg: shared types and constants for the integer numeral parser
// no dependencies; imported by inp_front, inp_back, integer_numeral_parser and the testbench
`default_nettype none

package inp_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MID_DEPTH      = 2;
  localparam int OUT_DEPTH      = 2;

  // parse phase of the back part
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  // classified character, front to back
  typedef struct packed {
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_nul;
    logic       alnum;
    logic [5:0] dval;
  } char_class_t;

endpackage

`default_nettype wire

@@ hdl/inp_fifo.sv @@
// inp_fifo: small register queue, first word through
// no dependencies; used twice in integer_numeral_parser
`default_nettype none

module inp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/inp_front.sv @@
// inp_front: classifies one input byte for the parse engine
// depends on inp_pkg
`default_nettype none

module inp_front
  import inp_pkg::*;
(
  input  logic [7:0]  char_byte,
  output char_class_t cls
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] TEN      = 8'd10;

  logic [7:0] dv;

  always_comb begin
    dv        = '0;
    cls.alnum = 1'b1;
    if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
      dv = char_byte - CH_ZERO;
    end else if (char_byte >= CH_LA && char_byte <= CH_LZ) begin
      dv = char_byte - CH_LA + TEN;
    end else if (char_byte >= CH_UA && char_byte <= CH_UZ) begin
      dv = char_byte - CH_UA + TEN;
    end else begin
      cls.alnum = 1'b0;
    end
    cls.dval     = dv[5:0];
    cls.is_space = (char_byte == CH_SPACE) || (char_byte >= CH_TAB && char_byte <= CH_CR);
    cls.is_plus  = (char_byte == CH_PLUS);
    cls.is_minus = (char_byte == CH_MINUS);
    cls.is_zero  = (char_byte == CH_ZERO);
    cls.is_x     = (char_byte == CH_LX) || (char_byte == CH_UX);
    cls.is_nul   = (char_byte == '0);
  end

endmodule

`default_nettype wire

@@ hdl/inp_back.sv @@
// inp_back: parse engine, emits a result on nul; one classified byte per cycle
// while bytes wait and no nul meets a full result queue; depends on inp_pkg
`default_nettype none

module inp_back
  import inp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_empty,
  input  char_class_t           mid_cls,
  output logic                  mid_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic                  res_ok,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [COUNT_BITS-1:0] res_count
);

  localparam int WB = VALUE_BITS + 4;

  phase_t                phase_r, phase_nxt, ph_s;
  radix_t                radix_r, radix_nxt, rad_s;
  logic                  neg_r, neg_nxt, neg_s;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt, mag_s;
  logic                  saw_r, saw_nxt, saw_s;
  logic                  fail_r, fail_nxt, fail_s;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_s;
  logic                  emit;

  // take a byte unless it is the terminator and the result queue is full
  assign mid_pop  = !mid_empty && (!res_full || !mid_cls.is_nul);
  assign res_push = mid_pop && emit;

  // next state: step the parse, then fall back to the start on the terminator
  always_comb begin
    logic          stop;
    logic [WB-1:0] ext;
    logic [WB-1:0] acc;
    logic [5:0]    base;
    ph_s   = phase_r;
    rad_s  = radix_r;
    neg_s  = neg_r;
    mag_s  = mag_r;
    saw_s  = saw_r;
    fail_s = fail_r;
    cnt_s  = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    emit   = 1'b0;
    stop   = 1'b0;
    ext    = {4'b0, mag_r};
    acc    = '0;
    base   = 6'd10;

    if (ph_s == PH_LEAD) begin
      if (mid_cls.is_space) begin
        stop = 1'b1;
      end else begin
        ph_s = PH_SIGN;
        if (mid_cls.is_plus || mid_cls.is_minus) begin
          neg_s = mid_cls.is_minus;
          stop  = 1'b1;
        end
      end
    end
    if (!stop) begin
      if (ph_s == PH_SIGN) begin
        if (mid_cls.is_zero) begin
          ph_s = PH_ZERO;
          stop = 1'b1;
        end else begin
          rad_s = RADIX_DEC;
          ph_s  = PH_DIGITS;
        end
      end else if (ph_s == PH_ZERO) begin
        ph_s = PH_DIGITS;
        if (mid_cls.is_x) begin
          rad_s = RADIX_HEX;
          stop  = 1'b1;
        end else begin
          rad_s = RADIX_OCT;
          saw_s = 1'b1;
        end
      end
    end
    // magnitude * base + digit by shifts, top bits flag overflow
    case (rad_s)
      RADIX_HEX: begin
        base = 6'd16;
        acc  = (ext << 4) + WB'(mid_cls.dval);
      end
      RADIX_OCT: begin
        base = 6'd8;
        acc  = (ext << 3) + WB'(mid_cls.dval);
      end
      default: begin
        base = 6'd10;
        acc  = (ext << 3) + (ext << 1) + WB'(mid_cls.dval);
      end
    endcase
    if (!stop && ph_s == PH_DIGITS) begin
      if (mid_cls.alnum && mid_cls.dval < base) begin
        stop = 1'b1;
        if (|acc[WB-1:VALUE_BITS]) begin
          fail_s = 1'b1;
          ph_s   = PH_TRAIL;
        end else begin
          mag_s = acc[VALUE_BITS-1:0];
          saw_s = 1'b1;
        end
      end else begin
        ph_s = PH_TRAIL;
      end
    end
    // trailing phase, also taken by unused phase codes
    if (!stop) begin
      if (!mid_cls.is_nul) begin
        if (!mid_cls.is_space) begin
          fail_s = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      phase_nxt = PH_LEAD;
      radix_nxt = RADIX_DEC;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      saw_nxt   = 1'b0;
      fail_nxt  = 1'b0;
      cnt_nxt   = '0;
    end else begin
      phase_nxt = ph_s;
      radix_nxt = rad_s;
      neg_nxt   = neg_s;
      mag_nxt   = mag_s;
      saw_nxt   = saw_s;
      fail_nxt  = fail_s;
      cnt_nxt   = cnt_s;
    end
  end

  // result word: range check outside hex, then signed value
  always_comb begin
    logic ok;
    ok = !fail_s && saw_s;
    if (ok && rad_s != RADIX_HEX) begin
      if (!neg_s && mag_s[VALUE_BITS-1]) begin
        ok = 1'b0;
      end
      if (neg_s && mag_s[VALUE_BITS-1] && |mag_s[VALUE_BITS-2:0]) begin
        ok = 1'b0;
      end
    end
    res_ok    = ok;
    res_value = ok ? (neg_s ? ('0 - mag_s) : mag_s) : '0;
    res_count = cnt_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      radix_r <= RADIX_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      saw_r   <= 1'b0;
      fail_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (mid_pop) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      saw_r   <= saw_nxt;
      fail_r  <= fail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/integer_numeral_parser.sv @@
// integer_numeral_parser: top level, byte-wise signed integer numeral parser
// depends on inp_pkg, inp_fifo, inp_front, inp_back
`default_nettype none

// channel   direction  ports                                     handshake
// input     in         in_char_byte                              in_push / in_full
// result    out        out_ok, out_value, out_byte_count         out_empty / out_pop
//
// sustained rate is one byte per cycle while the result queue has room for each result; the parse
//   engine handles one classified word per cycle when one waits, with shifts and adds for the base multiply
// a nul byte goes through the byte queue, after any older waiting bytes, to the engine, whose
//   result is registered in the result queue before it shows on the result ports
// reset is synchronous and clears both queues and the parse state; no clearing pass
// in_full rises when the two-word byte queue is full; the engine holds a nul byte
//   back only while the two-word result queue is full

module integer_numeral_parser
  import inp_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [7:0]                   in_char_byte,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_ok,
  output logic signed [VALUE_BITS-1:0] out_value,
  output logic [COUNT_BITS-1:0]        out_byte_count
);

  localparam int CW = $bits(char_class_t);
  localparam int RW = 1 + VALUE_BITS + COUNT_BITS;

  char_class_t           front_cls;
  logic [CW-1:0]         mid_rdata;
  char_class_t           mid_cls;
  logic                  mid_empty;
  logic                  mid_pop;
  logic                  res_full;
  logic                  res_push;
  logic                  res_ok;
  logic [VALUE_BITS-1:0] res_value;
  logic [COUNT_BITS-1:0] res_count;
  logic [RW-1:0]         out_rdata;

  // front: classify the incoming byte
  inp_front u_front (
    .char_byte (in_char_byte),
    .cls       (front_cls)
  );

  // short queue between classifier and engine
  inp_fifo #(
    .WIDTH (CW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (front_cls),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_cls = char_class_t'(mid_rdata);

  // back: parse engine
  inp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_cls   (mid_cls),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_ok    (res_ok),
    .res_value (res_value),
    .res_count (res_count)
  );

  // result queue, parts the engine from the consumer
  inp_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_ok, res_value, res_count}),
    .full  (res_full),
    .pop   (out_pop && !out_empty),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_ok         = out_rdata[RW-1];
  assign out_value      = out_rdata[VALUE_BITS+COUNT_BITS-1:COUNT_BITS];
  assign out_byte_count = out_rdata[COUNT_BITS-1:0];

  // a rejected numeral always carries a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_ok |-> out_value == '0)
    else $error("failed numeral with non-zero value");

  // every result comes from a terminator word taken by the engine
  a_push_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> mid_pop && mid_cls.is_nul)
    else $error("result without terminator");

  // the terminator itself is counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_byte_count != '0)
    else $error("zero byte count");

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

endmodule

`default_nettype wire

@@ dv/tb_integer_numeral_parser.sv @@
// tb_integer_numeral_parser: self-checking testbench for the byte-wise integer numeral parser
// depends on inp_pkg and integer_numeral_parser; predicts each numeral's result from the
// bytes taken in and compares it with every word that leaves the block
module tb_integer_numeral_parser
  import inp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = VALUE_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;

  // one character word waiting to be sent
  typedef struct {
    logic [7:0] ch;
    bit         drain_first;  // hold this word back until no result is outstanding
    bit         calm;         // closing part of the run: no idling on either side
  } char_word_t;

  // one parsed numeral as the block should report it
  typedef struct packed {
    logic          ok;
    logic [VB-1:0] value;
    logic [CB-1:0] byte_count;
  } numeral_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [7:0]           in_char_byte = 8'h00;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_ok;
  logic signed [VB-1:0] out_value;
  logic [CB-1:0]        out_byte_count;

  char_word_t pending_chars[$];
  numeral_t   expected_numerals[$];

  // parser state as predicted by the testbench
  phase_t        acc_phase = PH_LEAD;
  radix_t        acc_radix = RADIX_DEC;
  logic          acc_neg = 1'b0;
  logic [VB-1:0] acc_mag = '0;
  logic          acc_saw = 1'b0;
  logic          acc_failed = 1'b0;
  logic [CB-1:0] acc_count = '0;

  bit calm_now = 1'b0;
  bit drain_next = 1'b0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int pop_gap = 0;
  int chars_taken = 0;
  int numerals_checked = 0;
  int numerals_valid = 0;
  int mismatches = 0;

  integer_numeral_parser i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_char_byte  (in_char_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_ok        (out_ok),
    .out_value     (out_value),
    .out_byte_count(out_byte_count)
  );

  always #5 clk = ~clk;

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // advance the predicted parse by one byte; returns 1 when the byte closes a numeral
  function automatic bit parse_char(input logic [7:0] c, output numeral_t res);
    logic [VB-1:0] mag_max;
    logic [VB-1:0] lim;
    logic [VB-1:0] base;
    logic [VB-1:0] dig;
    logic          ok;
    res = '0;
    mag_max = '1;
    lim = '0;
    lim[VB-1] = 1'b1;
    if (acc_count != '1) acc_count++;

    if (acc_phase == PH_LEAD) begin
      if (is_blank(c)) return 1'b0;
      acc_phase = PH_SIGN;
      if (c == "+" || c == "-") begin
        acc_neg = (c == "-");
        return 1'b0;
      end
    end
    if (acc_phase == PH_SIGN) begin
      if (c == "0") begin
        acc_phase = PH_ZERO;
        return 1'b0;
      end
      acc_radix = RADIX_DEC;
      acc_phase = PH_DIGITS;
    end else if (acc_phase == PH_ZERO) begin
      if (c == "x" || c == "X") begin
        acc_radix = RADIX_HEX;
        acc_phase = PH_DIGITS;
        return 1'b0;
      end
      // the lone zero is itself an octal digit
      acc_radix = RADIX_OCT;
      acc_saw = 1'b1;
      acc_phase = PH_DIGITS;
    end
    if (acc_phase == PH_DIGITS) begin
      case (acc_radix)
        RADIX_HEX: base = 16;
        RADIX_OCT: base = 8;
        default:   base = 10;
      endcase
      if (c >= "0" && c <= "9") dig = c - "0";
      else if (c >= "a" && c <= "z") dig = c - "a" + 10;
      else if (c >= "A" && c <= "Z") dig = c - "A" + 10;
      else dig = 255;
      if (dig < base) begin
        if (acc_mag > (mag_max - dig) / base) begin
          acc_failed = 1'b1;
          acc_phase = PH_TRAIL;
        end else begin
          acc_mag = acc_mag * base + dig;
          acc_saw = 1'b1;
        end
        return 1'b0;
      end
      acc_phase = PH_TRAIL;
    end
    // trailing part: only blanks may follow until the nul
    if (c != 8'h00) begin
      if (!is_blank(c)) acc_failed = 1'b1;
      return 1'b0;
    end

    ok = !acc_failed && acc_saw;
    if (ok && acc_radix != RADIX_HEX) begin
      if (!acc_neg && acc_mag >= lim) ok = 1'b0;
      if (acc_neg && acc_mag > lim) ok = 1'b0;
    end
    res.ok = ok;
    res.value = !ok ? '0 : (acc_neg ? ~acc_mag + 1'b1 : acc_mag);
    res.byte_count = acc_count;

    acc_phase = PH_LEAD;
    acc_radix = RADIX_DEC;
    acc_neg = 1'b0;
    acc_mag = '0;
    acc_saw = 1'b0;
    acc_failed = 1'b0;
    acc_count = '0;
    return 1'b1;
  endfunction

  function automatic void push_char(logic [7:0] c);
    pending_chars.push_back('{c, drain_next, calm_now});
    drain_next = 1'b0;
  endfunction

  function automatic void push_text(string s, bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      push_char(c);
    end
  endfunction

  function automatic void add_numeral(string s);
    push_text(s, 1'b0);
    push_char(8'h00);
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? 8'd32 : 8'(8 + k);
  endfunction

  // magnitudes cluster around the range limits and the overflow thresholds
  function automatic logic [63:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} >> $urandom_range(1, 63);
      2: return 64'h8000_0000_0000_0000 - 2 + $urandom_range(0, 4);
      3: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      4: begin
        case ($urandom_range(0, 2))
          0: return 64'h1999_9999_9999_9999 + $urandom_range(0, 1);
          1: return 64'h1FFF_FFFF_FFFF_FFFF + $urandom_range(0, 1);
          default: return 64'h0FFF_FFFF_FFFF_FFFF + $urandom_range(0, 1);
        endcase
      end
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  function automatic void add_random_numeral();
    logic [63:0] mag;
    string       body;
    int          radix;
    repeat ($urandom_range(0, 2)) push_char(blank_char());
    case ($urandom_range(0, 3))
      0: push_char("-");
      1: push_char("+");
      default: ;
    endcase
    radix = $urandom_range(0, 2);
    mag = pick_magnitude();
    case (radix)
      0: body = $sformatf("%0d", mag);
      1: body = $sformatf("0%0o", mag);
      default: begin
        if ($urandom_range(0, 15) == 0) body = "0x";
        else if ($urandom_range(0, 1) == 1) body = $sformatf("0x%h", mag);
        else body = $sformatf("0X%0h", mag);
      end
    endcase
    push_text(body, 1'b1);
    // one more digit pushes boundary magnitudes over the top
    if ($urandom_range(0, 7) == 0) push_char(8'("0" + $urandom_range(0, 7)));
    if ($urandom_range(0, 7) == 0) push_char(8'($urandom_range(1, 255)));
    repeat ($urandom_range(0, 2)) push_char(blank_char());
    if ($urandom_range(0, 15) == 0) begin
      push_char(" ");
      push_char("3");
    end
    push_char(8'h00);
  endfunction

  // sender: presents the oldest pending word, idles in bursts
  always @(posedge clk) begin
    numeral_t parsed;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_char_byte <= 8'h00;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        // word taken at this edge
        if (parse_char(in_char_byte, parsed)) expected_numerals.push_back(parsed);
        void'(pending_chars.pop_front());
        chars_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_push <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        in_push <= 1'b0;
      end else if (pending_chars[0].drain_first && expected_numerals.size() != 0) begin
        in_push <= 1'b0;
      end else if (!pending_chars[0].calm && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_char_byte <= pending_chars[0].ch;
        quiet = pending_chars[0].calm;
      end
    end
  end

  // receiver: takes results and checks each against the oldest prediction
  always @(posedge clk) begin
    numeral_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_numerals.size() == 0) begin
          $error("unexpected result word: ok=%0b value=%0d byte_count=%0d",
                 out_ok, out_value, out_byte_count);
          mismatches++;
        end else begin
          want = expected_numerals.pop_front();
          numerals_checked++;
          if (want.ok) numerals_valid++;
          if (out_ok !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, out_ok);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), out_value);
            mismatches++;
          end
          if (out_byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, out_byte_count);
            mismatches++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(0, 14);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    int start_size;
    int numeral_idx;

    // directed: range edges, wrap and overflow in each base, malformed forms
    add_numeral("0");
    add_numeral("9223372036854775807");
    add_numeral("-9223372036854775808");
    add_numeral("9223372036854775808");
    add_numeral("-9223372036854775809");
    add_numeral("18446744073709551616");
    add_numeral("0xFFFFFFFFFFFFFFFF");
    add_numeral("-0x8000000000000001");
    add_numeral("0x10000000000000000");
    add_numeral("01777777777777777777777");
    add_numeral("-01000000000000000000000");
    add_numeral("0777");
    add_numeral("089");
    add_numeral("0x");
    add_numeral("");
    add_numeral("+");
    add_numeral("- 5");
    add_numeral("\011\012\013\014\015 +42 \011\015");
    add_numeral("12 3");
    add_numeral("12a");
    add_numeral("0XaBcDeF09");
    add_numeral("0xfZ");
    add_numeral("7\377");

    // random: mostly well-formed numerals, the rest loose noise
    start_size = pending_chars.size();
    numeral_idx = 0;
    while (pending_chars.size() - start_size < 870) begin
      calm_now = (pending_chars.size() - start_size > 780);
      if (numeral_idx % 25 == 0) drain_next = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 3) != 0) push_char(8'h00);
      end else begin
        add_random_numeral();
      end
      numeral_idx++;
    end
    add_numeral("-1");

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() != 0 || in_push || expected_numerals.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d characters; checked %0d numerals (%0d valid, %0d rejected)",
             chars_taken, numerals_checked, numerals_valid, numerals_checked - numerals_valid);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20_000_000;
    $display("timeout: %0d characters still pending, %0d results outstanding",
             pending_chars.size(), expected_numerals.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
